[src/gtr_pkg.sv]
package gtr_pkg;

    localparam int GLYPH_ROWS_DEF  = 16;
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int GLYPH_COLS      = 8;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_DRAW   = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;

    localparam logic [1:0] REG_FRAME_BASE    = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;
    localparam logic [1:0] REG_LINE_PITCH    = 2'd3;

    typedef struct packed {
        logic load_font;
        logic cursor_load;
        logic newline;
        logic draw;
        logic mul;
        logic base;
        logic issue;
    } dp_cmd_t;

    typedef struct packed {
        logic in_newline;
        logic last_issue;
    } dp_sts_t;

endpackage

[src/gtr_ctrl.sv]
module gtr_ctrl
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gtr_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  gtr_pkg::dp_sts_t                   sts,
    output gtr_pkg::dp_cmd_t                   cmd
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_BASE, S_ROWS} state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   take;

    assign s_axis_tready = ready_reg;
    assign take          = s_axis_tvalid && ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (s_axis_tuser)
                        gtr_pkg::OP_LOAD:   cmd.load_font   = 1'b1;
                        gtr_pkg::OP_CURSOR: cmd.cursor_load = 1'b1;
                        gtr_pkg::OP_DRAW:
                        begin
                            if (sts.in_newline)
                            begin
                                cmd.newline = 1'b1;
                            end
                            else
                            begin
                                cmd.draw   = 1'b1;
                                state_next = S_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = S_ROWS;
            end
            S_ROWS:
            begin
                cmd.issue = 1'b1;
                if (sts.last_issue)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

[src/gtr_datapath.sv]
module gtr_datapath #(
    parameter int GLYPH_ROWS  = gtr_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = gtr_pkg::GLYPH_COUNT_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gtr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gtr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [gtr_pkg::IN_TDATA_W-1:0]     in_tdata,
    input  gtr_pkg::dp_cmd_t                   cmd,
    output gtr_pkg::dp_sts_t                   sts,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gtr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GLYPH_ROWS);
    localparam int FW    = 8 + RW;
    localparam logic [RW-1:0] ROW_LAST = RW'(GLYPH_ROWS - 1);
    localparam logic [8:0]    COUNT_LIM = 9'(GLYPH_COUNT);
    localparam logic [5:0]    ROWS_LIM  = 6'(GLYPH_ROWS);

    logic [7:0]  in_char;
    logic [3:0]  in_grow;
    logic [7:0]  in_gbits;
    logic [15:0] in_col;
    logic [15:0] in_line;
    logic [31:0] in_color;

    assign in_char  = in_tdata[7:0];
    assign in_grow  = in_tdata[11:8];
    assign in_gbits = in_tdata[19:12];
    assign in_col   = in_tdata[35:20];
    assign in_line  = in_tdata[51:36];
    assign in_color = in_tdata[83:52];

    logic [63:0]    base_reg;
    logic [15:0]    width_reg;
    logic [15:0]    height_reg;
    logic [19:0]    pitch_reg;
    logic [15:0]    cursor_col_reg;
    logic [15:0]    cursor_line_reg;
    logic [7:0]     draw_code_reg;
    logic           code_ok_reg;
    logic [31:0]    color_reg;
    logic [35:0]    prod_reg;
    logic [63:0]    iss_addr_reg;
    logic [16:0]    iss_line_reg;
    logic [RW-1:0]  row_reg;
    logic [7:0]     colmask_reg;
    logic           b_valid_reg;
    logic [63:0]    b_addr_reg;
    logic [7:0]     b_mask_reg;
    logic           b_last_reg;
    logic [31:0]    b_color_reg;
    logic [7:0]     mem_q_reg;
    logic           out_valid_reg;
    logic [63:0]    out_addr_reg;
    logic [7:0]     out_mask_reg;
    logic [31:0]    out_color_reg;
    logic           out_last_reg;

    logic [7:0]     store [DEPTH];

    logic           out_load;
    logic           issue_fire;
    logic           wr_ok;
    logic [FW-1:0]  wr_full;
    logic [FW-1:0]  rd_full;
    logic [7:0]     colmask_next;

    assign out_load   = b_valid_reg && (!out_valid_reg || m_axis_tready);
    assign issue_fire = cmd.issue && (!b_valid_reg || out_load);
    assign wr_ok      = ({1'b0, in_char} < COUNT_LIM) && ({2'b00, in_grow} < ROWS_LIM);
    assign wr_full    = FW'(in_char) * FW'(GLYPH_ROWS) + FW'(in_grow);
    assign rd_full    = FW'(draw_code_reg) * FW'(GLYPH_ROWS) + FW'(row_reg);

    assign sts.in_newline = (in_char == gtr_pkg::NEWLINE_CODE);
    assign sts.last_issue = issue_fire && (row_reg == ROW_LAST);

    always_comb
    begin
        for (int c = 0; c < gtr_pkg::GLYPH_COLS; c++)
        begin
            colmask_next[gtr_pkg::GLYPH_COLS-1-c] =
                (({1'b0, cursor_col_reg} + 17'(c)) < {1'b0, width_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_font && wr_ok)
        begin
            store[wr_full[AW-1:0]] <= in_gbits;
        end
        if (issue_fire)
        begin
            mem_q_reg <= store[rd_full[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            pitch_reg       <= '0;
            cursor_col_reg  <= '0;
            cursor_line_reg <= '0;
            row_reg         <= '0;
            b_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gtr_pkg::REG_FRAME_BASE:    base_reg   <= cfg_data;
                    gtr_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data[15:0];
                    gtr_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data[15:0];
                    gtr_pkg::REG_LINE_PITCH:    pitch_reg  <= cfg_data[19:0];
                    default: ;
                endcase
            end
            if (cmd.cursor_load)
            begin
                cursor_col_reg  <= in_col;
                cursor_line_reg <= in_line;
            end
            if (cmd.newline)
            begin
                cursor_col_reg  <= '0;
                cursor_line_reg <= cursor_line_reg + 16'(GLYPH_ROWS);
            end
            if (cmd.base)
            begin
                row_reg <= '0;
            end
            if (issue_fire)
            begin
                if (row_reg == ROW_LAST)
                begin
                    cursor_col_reg <= cursor_col_reg + 16'(gtr_pkg::GLYPH_COLS);
                end
                row_reg <= row_reg + RW'(1);
            end
            if (issue_fire)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                b_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            draw_code_reg <= in_char;
            code_ok_reg   <= ({1'b0, in_char} < COUNT_LIM);
            color_reg     <= in_color;
        end
        if (cmd.mul)
        begin
            prod_reg <= 36'(cursor_line_reg) * 36'(pitch_reg);
        end
        if (cmd.base)
        begin
            iss_addr_reg <= base_reg + 64'(prod_reg) + {46'b0, cursor_col_reg, 2'b00};
            iss_line_reg <= {1'b0, cursor_line_reg};
            colmask_reg  <= colmask_next;
        end
        if (issue_fire)
        begin
            b_addr_reg   <= iss_addr_reg;
            b_mask_reg   <= colmask_reg
                          & {8{code_ok_reg && (iss_line_reg < {1'b0, height_reg})}};
            b_last_reg   <= (row_reg == ROW_LAST);
            b_color_reg  <= color_reg;
            iss_addr_reg <= iss_addr_reg + {44'b0, pitch_reg};
            iss_line_reg <= iss_line_reg + 17'd1;
        end
        if (out_load)
        begin
            out_addr_reg  <= b_addr_reg;
            out_mask_reg  <= mem_q_reg & b_mask_reg;
            out_color_reg <= b_color_reg;
            out_last_reg  <= b_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_color_reg, out_mask_reg, out_addr_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[src/glyph_text_renderer_core.sv]
// Text console character generator with a loadable 8-pixel-wide bitmap font.
// Each request carries an opcode in s_axis_tuser: load one font byte, draw a
// character, or set the pixel cursor. Loads, cursor sets and newlines complete
// in the cycle that accepts them. A drawn character runs its address setup
// (cursor row times pitch, then the start address) and then emits GLYPH_ROWS
// row writes, one per cycle while the output is not stalled, as the registered
// font memory read port delivers them. Every row write gives the byte address
// of its leftmost pixel, an 8-pixel mask clipped to the screen and the color;
// tlast marks the final row. The font store has no reset, so glyphs must be
// loaded before they are drawn. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while idle, as the
// block itself does not enforce it.
module glyph_text_renderer_core #(
    parameter int GLYPH_ROWS  = gtr_pkg::GLYPH_ROWS_DEF,
    parameter int GLYPH_COUNT = gtr_pkg::GLYPH_COUNT_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gtr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gtr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // char_code[7:0], glyph_row[11:8], glyph_bits[19:12], new_col[35:20],
    // new_line[51:36], color[83:52], zero[87:84]
    input  logic [gtr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // opcode[1:0]
    input  logic [gtr_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // row_address[63:0], pixel_mask[71:64], pixel_color[103:72]
    output logic [gtr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);

    gtr_pkg::dp_cmd_t cmd;
    gtr_pkg::dp_sts_t sts;

    gtr_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .sts           (sts),
        .cmd           (cmd)
    );

    gtr_datapath #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_tdata      (s_axis_tdata),
        .cmd           (cmd),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    a_no_take_while_issuing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !s_axis_tready)
        else $error("request accepted while glyph rows are being issued");

    a_idle_after_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        sts.last_issue |=> s_axis_tready)
        else $error("controller did not return to idle after the last row");

    a_draw_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw |=> cmd.mul ##1 cmd.base)
        else $error("draw request did not run the address setup");
`endif

endmodule

[tb/sv/glyph_text_renderer_core_tb.sv]
`timescale 1ns / 100ps

module glyph_text_renderer_core_tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SETTLE      = 40;
    localparam int         HOLD_CYCLES = 400;
    localparam int         LIMIT       = 200000;
    localparam int         G_ROWS      = gtr_pkg::GLYPH_ROWS_DEF;
    localparam int         G_COUNT     = gtr_pkg::GLYPH_COUNT_DEF;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  code;
        logic [3:0]  grow;
        logic [7:0]  gbits;
        logic [15:0] ncol;
        logic [15:0] nline;
        logic [31:0] color;
    } glyph_req_t;

    typedef struct packed {
        logic [63:0] addr;
        logic [7:0]  mask;
        logic [31:0] color;
        logic        last;
    } row_write_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [gtr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gtr_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [gtr_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [gtr_pkg::IN_TUSER_W-1:0]  s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [gtr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    logic [7:0]  font_mem [0:G_COUNT*G_ROWS-1];
    bit          font_loaded [0:G_COUNT*G_ROWS-1];
    bit          glyph_ready [0:G_COUNT-1];
    logic [7:0]  ready_codes [$];
    logic [15:0] cur_col;
    logic [15:0] cur_line;
    logic [63:0] reg_base;
    logic [15:0] reg_width;
    logic [15:0] reg_height;
    logic [19:0] reg_pitch;

    row_write_t  pending_rows [$];

    int          err_cnt       = 0;
    int          cycles        = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          in_valid_up   = 1'b0;
    logic        hold_tgl      = 1'b0;
    logic        hold_seen     = 1'b0;
    int          hold_left     = 0;

    glyph_text_renderer_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_tgl != hold_seen)
        begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        row_write_t got;
        row_write_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.addr  = m_axis_tdata[63:0];
            got.mask  = m_axis_tdata[71:64];
            got.color = m_axis_tdata[103:72];
            got.last  = m_axis_tlast;
            if (pending_rows.size() == 0)
            begin
                if (err_cnt < 10)
                    $display("unexpected row write: addr=%h mask=%h color=%h last=%b",
                             got.addr, got.mask, got.color, got.last);
                err_cnt++;
            end
            else
            begin
                want = pending_rows.pop_front();
                if (got !== want)
                begin
                    if (err_cnt < 10)
                    begin
                        $display("row write mismatch: expected addr=%h mask=%h color=%h last=%b",
                                 want.addr, want.mask, want.color, want.last);
                        $display("                    actual   addr=%h mask=%h color=%h last=%b",
                                 got.addr, got.mask, got.color, got.last);
                    end
                    err_cnt++;
                end
            end
        end
    end

    function automatic void model_request(input glyph_req_t rq);
        row_write_t  rw;
        logic [16:0] line;
        logic [7:0]  bits;
        int          idx;
        bit          full;
        case (rq.op)
            gtr_pkg::OP_LOAD:
            begin
                idx = int'(rq.code) * G_ROWS + int'(rq.grow);
                font_mem[idx]    = rq.gbits;
                font_loaded[idx] = 1'b1;
                full = 1'b1;
                for (int r = 0; r < G_ROWS; r++)
                    if (!font_loaded[int'(rq.code) * G_ROWS + r])
                        full = 1'b0;
                if (full && !glyph_ready[rq.code])
                begin
                    glyph_ready[rq.code] = 1'b1;
                    ready_codes.push_back(rq.code);
                end
            end
            gtr_pkg::OP_CURSOR:
            begin
                cur_col  = rq.ncol;
                cur_line = rq.nline;
            end
            gtr_pkg::OP_DRAW:
            begin
                if (rq.code == gtr_pkg::NEWLINE_CODE)
                begin
                    cur_col  = 16'd0;
                    cur_line = cur_line + 16'(G_ROWS);
                end
                else
                begin
                    for (int r = 0; r < G_ROWS; r++)
                    begin
                        line = {1'b0, cur_line} + 17'(r);
                        bits = font_mem[int'(rq.code) * G_ROWS + r];
                        if (line >= {1'b0, reg_height})
                            bits = 8'd0;
                        for (int c = 0; c < gtr_pkg::GLYPH_COLS; c++)
                            if (int'(cur_col) + c >= int'(reg_width))
                                bits[7-c] = 1'b0;
                        rw.addr  = reg_base + 64'(line) * 64'(reg_pitch)
                                 + 64'(cur_col) * 64'd4;
                        rw.mask  = bits;
                        rw.color = rq.color;
                        rw.last  = (r == G_ROWS - 1);
                        pending_rows.push_back(rw);
                    end
                    cur_col = cur_col + 16'(gtr_pkg::GLYPH_COLS);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic glyph_req_t make_req(input logic [1:0] op, input logic [7:0] code);
        glyph_req_t rq;
        rq.op    = op;
        rq.code  = code;
        rq.grow  = 4'($urandom);
        rq.gbits = 8'($urandom);
        rq.ncol  = 16'($urandom);
        rq.nline = 16'($urandom);
        rq.color = $urandom;
        return rq;
    endfunction

    task automatic park_input(input int n);
        if (in_valid_up)
        begin
            s_axis_tvalid <= 1'b0;
            in_valid_up = 1'b0;
        end
        repeat (n) @(posedge clk);
    endtask

    task automatic send_req(input glyph_req_t rq);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
            park_input(gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.op;
        s_axis_tdata  <= {4'b0, rq.color, rq.nline, rq.ncol, rq.gbits, rq.grow, rq.code};
        in_valid_up = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        model_request(rq);
    endtask

    task automatic drain_results();
        park_input(0);
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_screen(input logic [63:0] base, input logic [15:0] w,
                              input logic [15:0] h, input logic [19:0] pitch);
        cfg_we    <= 1'b1;
        cfg_index <= gtr_pkg::REG_FRAME_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= gtr_pkg::REG_SCREEN_WIDTH;
        cfg_data  <= 64'(w);
        @(posedge clk);
        cfg_index <= gtr_pkg::REG_SCREEN_HEIGHT;
        cfg_data  <= 64'(h);
        @(posedge clk);
        cfg_index <= gtr_pkg::REG_LINE_PITCH;
        cfg_data  <= 64'(pitch);
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_base   = base;
        reg_width  = w;
        reg_height = h;
        reg_pitch  = pitch;
    endtask

    task automatic put_cursor(input logic [15:0] col, input logic [15:0] line);
        glyph_req_t rq;
        rq       = make_req(gtr_pkg::OP_CURSOR, 8'($urandom));
        rq.ncol  = col;
        rq.nline = line;
        send_req(rq);
    endtask

    task automatic put_glyph(input logic [7:0] code, input logic [31:0] color);
        glyph_req_t rq;
        rq       = make_req(gtr_pkg::OP_DRAW, code);
        rq.color = color;
        send_req(rq);
    endtask

    task automatic test_font_load();
        logic [7:0] codes [6];
        glyph_req_t rq;
        codes = '{8'h00, 8'hFF, 8'h41, 8'h5A, 8'hA5, 8'h3C};
        send_idle_pct = 15;
        recv_idle_pct = 0;
        foreach (codes[i])
        begin
            for (int r = 0; r < G_ROWS; r++)
            begin
                rq      = make_req(gtr_pkg::OP_LOAD, codes[i]);
                rq.grow = 4'(r);
                if (codes[i] == 8'hFF)
                    rq.gbits = 8'hFF;
                else if (codes[i] == 8'h00 && r == 0)
                    rq.gbits = 8'h00;
                send_req(rq);
            end
        end
        drain_results();
    endtask

    task automatic test_edge_cases();
        glyph_req_t rq;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_screen(64'd0, 16'd640, 16'd480, 20'd2560);
        put_glyph(8'h00, 32'h0000_0000);
        put_glyph(8'hFF, 32'hFFFF_FFFF);
        put_glyph(gtr_pkg::NEWLINE_CODE, $urandom);
        put_cursor(16'd636, 16'd100);
        put_glyph(8'h41, $urandom);
        put_cursor(16'd100, 16'd470);
        put_glyph(8'hFF, $urandom);
        put_cursor(16'hFFF8, 16'hFFF0);
        put_glyph(8'h5A, $urandom);
        put_glyph(8'hA5, $urandom);
        put_glyph(gtr_pkg::NEWLINE_CODE, $urandom);
        put_glyph(8'h3C, $urandom);
        rq = make_req(OP_UNUSED, 8'hFF);
        rq.ncol  = 16'hFFFF;
        rq.nline = 16'hFFFF;
        send_req(rq);
        put_glyph(8'h41, $urandom);
        drain_results();

        set_screen(64'hFFFF_FFFF_FFFF_FFF0, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
        put_cursor(16'hFFF9, 16'hFFF5);
        put_glyph(8'hFF, $urandom);
        put_cursor(16'hFFFF, 16'hFFFF);
        put_glyph(8'h3C, $urandom);
        drain_results();

        set_screen(64'd0, 16'd0, 16'd0, 20'd0);
        put_cursor(16'd0, 16'd0);
        put_glyph(8'hFF, $urandom);
        drain_results();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_screen(64'h0000_1000_0000_0000, 16'd1024, 16'd768, 20'd4096);
        put_cursor(16'd0, 16'd0);
        hold_tgl <= ~hold_tgl;
        for (int i = 0; i < 10; i++)
            put_glyph(ready_codes[$urandom_range(0, ready_codes.size() - 1)], $urandom);
        drain_results();
    endtask

    task automatic run_random(input int n, input int s_pct, input int r_pct);
        glyph_req_t rq;
        int         roll;
        int         col_span;
        int         line_span;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        col_span  = (int'(reg_width) > 65527) ? 65535 : int'(reg_width) + 8;
        line_span = (int'(reg_height) > 65527) ? 65535 : int'(reg_height) + 8;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                rq = make_req(gtr_pkg::OP_DRAW,
                              ready_codes[$urandom_range(0, ready_codes.size() - 1)]);
                if ($urandom_range(0, 9) == 0)
                    rq.code = gtr_pkg::NEWLINE_CODE;
            end
            else if (roll < 75)
            begin
                rq = make_req(gtr_pkg::OP_LOAD, 8'($urandom));
            end
            else if (roll < 92)
            begin
                rq = make_req(gtr_pkg::OP_CURSOR, 8'($urandom));
                if ($urandom_range(0, 3) != 0)
                begin
                    rq.ncol  = 16'($urandom_range(0, col_span));
                    rq.nline = 16'($urandom_range(0, line_span));
                end
            end
            else
            begin
                rq = make_req(OP_UNUSED, 8'($urandom));
            end
            send_req(rq);
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        set_screen({$urandom, $urandom}, 16'($urandom_range(64, 2048)),
                   16'($urandom_range(64, 1200)), 20'($urandom));
        run_random(10, 15, 46);
        set_screen(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
        run_random(10, 46, 15);
        set_screen(64'd0, 16'($urandom_range(8, 64)), 16'($urandom_range(8, 64)),
                   20'($urandom));
        run_random(10, 0, 0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cur_col       = 16'd0;
        cur_line      = 16'd0;
        reg_base      = 64'd0;
        reg_width     = 16'd0;
        reg_height    = 16'd0;
        reg_pitch     = 20'd0;
        foreach (font_mem[i])
        begin
            font_mem[i]    = 8'd0;
            font_loaded[i] = 1'b0;
        end
        foreach (glyph_ready[i])
            glyph_ready[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        test_font_load();
        test_edge_cases();
        test_backpressure();
        test_random_traffic();

        drain_results();
        err_cnt += pending_rows.size();
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
src/gtr_pkg.sv
src/gtr_ctrl.sv
src/gtr_datapath.sv
src/glyph_text_renderer_core.sv
tb/sv/glyph_text_renderer_core_tb.sv
